FILE: rtl/sorted_list_buffer_top_defines.svh
// Assertion macros shared by the sorted list buffer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SORTED_LIST_BUFFER_TOP_DEFINES_SVH
`define SORTED_LIST_BUFFER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/slb_pkg.sv
// Package for the sorted list buffer: field widths, action codes and the
// command struct broadcast to the cell row. No dependencies.
package slb_pkg;

    localparam int DATA_W       = 8;
    localparam int ACT_W        = 2;
    localparam int IDX_W        = 4;
    localparam int CNT_OUT_W    = 5;
    localparam int DEF_CAPACITY = 16;
    localparam int RD_MAX       = 16;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef struct packed {
        logic ins_en;
        logic rm_en;
    } t_cell_cmd;

endpackage

FILE: rtl/slb_if.sv
// Valid/ready channel interfaces for the sorted list buffer requests and
// responses. Depends on slb_pkg.
interface slb_req_if import slb_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ACT_W-1:0]         action;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         index;

    modport source (output valid, action, value, index, input ready);
    modport sink   (input valid, action, value, index, output ready);
endinterface

interface slb_rsp_if import slb_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_OUT_W-1:0]     count;

    modport source (output valid, ok, read_value, count, input ready);
    modport sink   (input valid, ok, read_value, count, output ready);
endinterface

FILE: rtl/slb_cell.sv
// One storage cell of the sorted row: holds a value, compares it with the
// broadcast operand and shifts with its neighbors. Depends on slb_pkg.
module slb_cell import slb_pkg::*; (
    input  logic                     i_clk,
    input  t_cell_cmd                i_cmd,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_occ,
    input  logic                     i_left_take,
    input  logic                     i_left_lt,
    input  logic signed [DATA_W-1:0] i_left_val,
    input  logic signed [DATA_W-1:0] i_right_val,
    output logic                     o_take,
    output logic                     o_lt,
    output logic                     o_hit,
    output logic signed [DATA_W-1:0] o_val
);

    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] n_val;

    // A cell at or behind the insert point is empty or holds a larger value.
    assign o_take = !i_occ || (r_val > i_value);
    assign o_lt   = i_occ && (r_val < i_value);
    // The first cell not below the operand reports a hit if it equals it.
    assign o_hit  = i_occ && !o_lt && i_left_lt && (r_val == i_value);
    assign o_val  = r_val;

    always_comb begin
        n_val = r_val;
        if (i_cmd.ins_en && o_take) begin
            n_val = i_left_take ? i_left_val : i_value;
        end else if (i_cmd.rm_en && !o_lt) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

FILE: rtl/slb_chain.sv
// Row of slb_cell instances wired to their neighbors, with occupancy taken
// from the fill count and the removal match reduced. Depends on slb_pkg.
module slb_chain import slb_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                              i_clk,
    input  t_cell_cmd                         i_cmd,
    input  logic signed [DATA_W-1:0]          i_value,
    input  logic [$clog2(CAPACITY+1)-1:0]     i_count,
    output logic                              o_found,
    output logic signed [DATA_W-1:0]          o_vals [CAPACITY]
);

    localparam int CNT_W = $clog2(CAPACITY+1);

    logic [CAPACITY-1:0] w_take;
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_hit;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic                     w_left_take;
        logic                     w_left_lt;
        logic signed [DATA_W-1:0] w_left_val;
        logic signed [DATA_W-1:0] w_right_val;

        if (gi == 0) begin : g_first
            assign w_left_take = 1'b0;
            assign w_left_lt   = 1'b1;
            assign w_left_val  = i_value;
        end else begin : g_inner
            assign w_left_take = w_take[gi-1];
            assign w_left_lt   = w_lt[gi-1];
            assign w_left_val  = o_vals[gi-1];
        end

        if (gi == CAPACITY-1) begin : g_last
            assign w_right_val = o_vals[gi];
        end else begin : g_next
            assign w_right_val = o_vals[gi+1];
        end

        slb_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (i_cmd),
            .i_value     (i_value),
            .i_occ       (CNT_W'(gi) < i_count),
            .i_left_take (w_left_take),
            .i_left_lt   (w_left_lt),
            .i_left_val  (w_left_val),
            .i_right_val (w_right_val),
            .o_take      (w_take[gi]),
            .o_lt        (w_lt[gi]),
            .o_hit       (w_hit[gi]),
            .o_val       (o_vals[gi])
        );
    end

    assign o_found = |w_hit;

endmodule

FILE: rtl/sorted_list_buffer_top.sv
// Top level of the sorted list buffer: request/response handshakes, fill
// count and result register around the cell row. Depends on slb_pkg,
// slb_if, slb_chain and sorted_list_buffer_top_defines.svh.
//
//   channel  | dir | handshake   | payload
//   ---------+-----+-------------+-------------------------------
//   i_req    | in  | valid/ready | action, value, index
//   o_rsp    | out | valid/ready | ok, read_value, count
//
// One transaction is taken per cycle; its result shows in the response
// register on the next cycle. The whole row compares against the operand and
// shifts by one place in the accepting cycle, which sets that rate.
// Synchronous active-low reset empties the list and drops the response.
// A new request is taken while the response register is empty or is being
// drained in the same cycle; a stalled response holds everything upstream.
`include "sorted_list_buffer_top_defines.svh"

module sorted_list_buffer_top import slb_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic i_clk,
    input  logic i_rst_n,
    slb_req_if.sink   i_req,
    slb_rsp_if.source o_rsp
);

    localparam int CNT_W = $clog2(CAPACITY+1);
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int RD_N  = (CAPACITY < RD_MAX) ? CAPACITY : RD_MAX;

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_out_valid;
    logic                     r_ok;
    logic                     n_ok;
    logic signed [DATA_W-1:0] r_rd;
    logic signed [DATA_W-1:0] n_rd;
    logic [CNT_OUT_W-1:0]     r_cnt_out;

    logic                     w_accept;
    logic                     w_full;
    logic                     w_found;
    logic                     w_is_ins;
    logic                     w_is_rm;
    t_cell_cmd                w_cmd;
    logic signed [DATA_W-1:0] w_vals [CAPACITY];
    logic signed [DATA_W-1:0] w_rd_sel;
    t_action                  w_action;

    assign w_action = t_action'(i_req.action);

    // The response register frees up in the same cycle it is drained.
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = r_count >= CNT_W'(CAPACITY);
    assign w_is_ins    = w_accept && (w_action == ACT_INSERT);
    assign w_is_rm     = w_accept && (w_action == ACT_REMOVE);

    assign w_cmd.ins_en = w_is_ins && !w_full;
    assign w_cmd.rm_en  = w_is_rm && w_found;

    slb_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .i_clk   (i_clk),
        .i_cmd   (w_cmd),
        .i_value (i_req.value),
        .i_count (r_count),
        .o_found (w_found),
        .o_vals  (w_vals)
    );

    // Only the first positions of the row can be addressed by the index field.
    always_comb begin
        w_rd_sel = '0;
        for (int i = 0; i < RD_N; i++) begin
            if (i_req.index == i[IDX_W-1:0]) begin
                w_rd_sel = w_vals[i];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        n_ok    = 1'b0;
        n_rd    = '0;
        case (w_action)
            ACT_INSERT: begin
                if (!w_full) begin
                    n_ok    = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            ACT_REMOVE: begin
                if (w_found) begin
                    n_ok    = 1'b1;
                    n_count = r_count - CNT_W'(1);
                end
            end
            ACT_READ: begin
                if (CMP_W'(i_req.index) < CMP_W'(r_count)) begin
                    n_ok = 1'b1;
                    n_rd = w_rd_sel;
                end
            end
            ACT_CLEAR: begin
                n_ok    = 1'b1;
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Response payload needs no reset; it is qualified by the valid flag.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ok      <= n_ok;
            r_rd      <= n_rd;
            r_cnt_out <= CNT_OUT_W'(n_count);
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.ok         = r_ok;
    assign o_rsp.read_value = r_rd;
    assign o_rsp.count      = r_cnt_out;

    `SLB_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY), "fill count above capacity")
    `SLB_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, w_cmd.ins_en, r_count == $past(r_count) + CNT_W'(1), "insert did not grow the count")
    `SLB_ASSERT_NEXT(a_remove_shrinks, i_clk, i_rst_n, w_cmd.rm_en, r_count == $past(r_count) - CNT_W'(1), "remove did not shrink the count")
    `SLB_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, w_accept && (w_action == ACT_CLEAR), (r_count == '0) && r_out_valid && r_ok, "clear did not empty the list")
    `SLB_ASSERT_NOW(a_found_nonempty, i_clk, i_rst_n, w_found, r_count != '0, "match reported in an empty list")

endmodule

FILE: tb/sorted_list_buffer_top_test.sv
// Self-checking testbench for sorted_list_buffer_top: directed and random list actions.
// A predictor in this file checks each response field by field.
// Depends on slb_pkg, slb_if and the sorted list buffer RTL.
`timescale 1ns / 1ps

module sorted_list_buffer_top_test;
    import slb_pkg::*;

    localparam int DEPTH          = DEF_CAPACITY;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // One expected response, laid out like the response channel payload.
    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] read_value;
        logic [CNT_OUT_W-1:0]     count;
    } t_slb_result;

    logic i_clk;
    logic i_rst_n;

    slb_req_if req_ch ();
    slb_rsp_if rsp_ch ();

    sorted_list_buffer_top #(
        .CAPACITY(DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    // Predicted contents of the list. Only positions below list_fill are valid.
    logic signed [DATA_W-1:0] list_entries [DEPTH];
    int                       list_fill = 0;

    // Responses that the block still owes, oldest first.
    t_slb_result expected_results[$];

    int mismatch_count = 0;
    int idle_cycles    = 0;

    // Percentages that shape the traffic on each side of the block.
    int send_idle_pct = 0;
    int rsp_stall_pct = 0;

    // The clock starts low, so the first rising edge falls at 10 ns.
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Applies one action to the predicted list and returns the response it
    // should produce. Insert goes behind every equal value; remove takes the
    // first equal value; read and clear never move entries.
    function automatic t_slb_result apply_to_list(input t_action act,
                                                  input logic signed [DATA_W-1:0] val,
                                                  input logic [IDX_W-1:0] idx);
        t_slb_result res;
        int          pos;
        int          k;
        res = '0;
        case (act)
            ACT_INSERT: begin
                if (list_fill < DEPTH) begin
                    pos = 0;
                    while (pos < list_fill && list_entries[pos] <= val) pos++;
                    for (k = list_fill; k > pos; k--) list_entries[k] = list_entries[k-1];
                    list_entries[pos] = val;
                    list_fill++;
                    res.ok = 1'b1;
                end
            end
            ACT_REMOVE: begin
                pos = 0;
                while (pos < list_fill && list_entries[pos] < val) pos++;
                if (pos < list_fill && list_entries[pos] == val) begin
                    for (k = pos; k + 1 < list_fill; k++) list_entries[k] = list_entries[k+1];
                    list_fill--;
                    res.ok = 1'b1;
                end
            end
            ACT_READ: begin
                if (int'(idx) < list_fill) begin
                    res.ok         = 1'b1;
                    res.read_value = list_entries[idx];
                end
            end
            default: begin
                list_fill = 0;
                res.ok    = 1'b1;
            end
        endcase
        res.count = list_fill[CNT_OUT_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int exp_val, input int act_val);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, exp_val,
                     act_val);
    endtask

    // Every rising edge: predict each accepted request transaction, check each
    // accepted response transaction against the oldest prediction, and keep
    // the watchdog that ends a run which stops making progress.
    always @(posedge i_clk) begin
        t_slb_result exp_res;
        logic        req_fire;
        logic        rsp_fire;
        req_fire = req_ch.valid && req_ch.ready;
        rsp_fire = rsp_ch.valid && rsp_ch.ready;

        if (req_fire)
            expected_results.push_back(apply_to_list(t_action'(req_ch.action), req_ch.value,
                                                     req_ch.index));

        if (rsp_fire) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected response, count", -1, rsp_ch.count);
            end else begin
                exp_res = expected_results.pop_front();
                if (rsp_ch.ok !== exp_res.ok)
                    report_mismatch("ok", exp_res.ok, rsp_ch.ok);
                if (rsp_ch.read_value !== exp_res.read_value)
                    report_mismatch("read_value", exp_res.read_value, rsp_ch.read_value);
                if (rsp_ch.count !== exp_res.count)
                    report_mismatch("count", exp_res.count, rsp_ch.count);
            end
        end

        if (req_fire || rsp_fire)
            idle_cycles = 0;
        else
            idle_cycles++;
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("sorted_list_buffer_top_test: errors");
            $finish;
        end
    end

    // The response side stalls at random, at the rate the current phase sets.
    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    // Sends one request transaction. Valid stays high after acceptance so that
    // back-to-back transactions follow one another directly; a random gap lowers it first.
    task automatic send_request(input t_action act, input logic signed [DATA_W-1:0] val,
                                input logic [IDX_W-1:0] idx);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.action <= act;
        req_ch.value  <= val;
        req_ch.index  <= idx;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Lowers valid and holds off until every owed response has come back.
    task automatic wait_for_results();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Empty list: remove and read both fail, clear still succeeds.
    task automatic test_empty_list();
        send_request(ACT_REMOVE, 8'sd5, 4'd0);
        send_request(ACT_READ, 8'sd0, 4'd0);
        send_request(ACT_CLEAR, 8'sd0, 4'd0);
    endtask

    // Extreme values, duplicates placed behind their equals, first-match
    // removal, a remove that falls between stored values, and a read one past
    // the end of the list.
    task automatic test_order_and_duplicates();
        send_request(ACT_INSERT, 8'sd127, 4'd0);
        send_request(ACT_INSERT, -8'sd128, 4'd0);
        send_request(ACT_INSERT, 8'sd0, 4'd0);
        send_request(ACT_INSERT, 8'sd0, 4'd0);
        send_request(ACT_INSERT, -8'sd1, 4'd0);
        send_request(ACT_READ, 8'sd0, 4'd0);
        send_request(ACT_READ, 8'sd0, 4'd4);
        send_request(ACT_READ, 8'sd0, 4'd5);
        send_request(ACT_REMOVE, 8'sd0, 4'd0);
        send_request(ACT_REMOVE, 8'sd3, 4'd0);
        send_request(ACT_REMOVE, 8'sd127, 4'd0);
        send_request(ACT_READ, 8'sd0, 4'd2);
        send_request(ACT_CLEAR, 8'sd0, 4'd0);
    endtask

    // Fill every slot, then insert into the full store, read the last slot and
    // clear the whole list.
    task automatic test_full_store();
        int n;
        for (n = 0; n < DEPTH; n++)
            send_request(ACT_INSERT, DATA_W'($urandom_range(255)), 4'd0);
        send_request(ACT_INSERT, 8'sd42, 4'd0);
        send_request(ACT_READ, 8'sd0, 4'd15);
        send_request(ACT_CLEAR, 8'sd0, 4'd0);
    endtask

    // Random traffic that favors insert and read so the list spends most of
    // its time partly or wholly full. Removes mostly name a value that is
    // stored, reads mostly name a valid position, and small values are common
    // so that duplicates pile up. drain_every > 0 makes the sender hold off
    // until every owed response has arrived, every that many transactions.
    task automatic run_random_traffic(input int n_items, input int drain_every);
        int                       n;
        int                       pick;
        t_action                  act;
        logic signed [DATA_W-1:0] val;
        logic [IDX_W-1:0]         idx;
        for (n = 0; n < n_items; n++) begin
            pick = $urandom_range(99);
            if (pick < 40)
                act = ACT_INSERT;
            else if (pick < 65)
                act = ACT_REMOVE;
            else if (pick < 97)
                act = ACT_READ;
            else
                act = ACT_CLEAR;

            if ($urandom_range(1))
                val = DATA_W'($urandom_range(255));
            else
                val = $signed(DATA_W'($urandom_range(8))) - 8'sd4;
            if (act == ACT_REMOVE && list_fill > 0 && $urandom_range(99) < 60)
                val = list_entries[$urandom_range(list_fill - 1)];

            if ($urandom_range(99) < 80)
                idx = IDX_W'(($urandom_range(list_fill) > 15) ? 15 : $urandom_range(list_fill));
            else
                idx = IDX_W'($urandom_range(15));

            send_request(act, val, idx);
            if (drain_every > 0 && (n % drain_every) == drain_every - 1)
                wait_for_results();
        end
    endtask

    task automatic test_random_no_idle();
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        run_random_traffic(500, 0);
    endtask

    task automatic test_random_sender_idle();
        send_idle_pct = 59;
        rsp_stall_pct = 0;
        run_random_traffic(500, 100);
    endtask

    task automatic test_random_receiver_stall();
        send_idle_pct = 0;
        rsp_stall_pct = 59;
        run_random_traffic(500, 0);
    endtask

    task automatic test_random_both_idle();
        send_idle_pct = 37;
        rsp_stall_pct = 37;
        run_random_traffic(500, 0);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.action = ACT_INSERT;
        req_ch.value  = '0;
        req_ch.index  = '0;
        rsp_ch.ready  = 1'b0;

        // Synchronous reset held low from the start, released on a falling edge.
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_order_and_duplicates();
        test_full_store();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();

        // Drain the last responses, then keep watching for stray responses.
        wait_for_results();
        repeat (4) @(posedge i_clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("sorted_list_buffer_top_test: clean");
        else
            $display("sorted_list_buffer_top_test: errors");
        $finish;
    end

endmodule
